@@ hw/rtl/sorted_extent_insert_merge_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted extent table: assertion macros
// Shared property forms used by the extent table top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_EXTENT_INSERT_MERGE_TOP_DEFINES_SVH
`define SORTED_EXTENT_INSERT_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SEIM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/seim_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted extent table package
// Field widths, request and status codes, and the per-cell control types.
// ----------------------------------------------------------------------------
package seim_pkg;

	localparam int CNT_W  = 37;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int XCNT_W = 7;
	localparam int OUT_DW = ((STAT_W + CNT_W + XCNT_W + 7) / 8) * 8;

	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	localparam logic CFG_TABLE_END = 1'b0;
	localparam logic CFG_INIT_FREE = 1'b1;

	// Table update chosen for one item.
	typedef enum logic [2:0] {
		OP_NONE        = 3'd0,
		OP_CLEAR       = 3'd1,
		OP_APPEND      = 3'd2,
		OP_MERGE_NEXT  = 3'd3,
		OP_SET_END     = 3'd4,
		OP_SET_NEXT_LO = 3'd5,
		OP_NEW         = 3'd6
	} op_t;

	typedef struct packed {
		op_t  op;
		logic apply;
		logic sel;
		logic sel_prev;
		logic gt;
		logic occ;
		logic has_next;
		logic here;
	} cell_ctl_t;

	typedef struct packed {
		logic fit;
		logic left;
		logic right;
		logic has_next;
	} cell_flags_t;

endpackage

@@ hw/rtl/seim_cell.sv @@
// ----------------------------------------------------------------------------
// Extent cell
// Holds one extent, checks whether the gap after it takes the request range,
// and shifts or rewrites its extent on the table update.
// ----------------------------------------------------------------------------
module seim_cell #(
	parameter int BLOCK_BITS = 36
) (
	input  logic                       clk,
	input  seim_pkg::cell_ctl_t        ctl,
	input  logic [BLOCK_BITS-1:0]      range_low,
	input  logic [BLOCK_BITS-1:0]      range_high,
	input  logic [seim_pkg::CNT_W-1:0] table_end,
	input  logic [BLOCK_BITS-1:0]      prev_start,
	input  logic [BLOCK_BITS-1:0]      prev_end,
	input  logic [BLOCK_BITS-1:0]      next_start,
	input  logic [BLOCK_BITS-1:0]      next_end,
	output logic [BLOCK_BITS-1:0]      ext_start,
	output logic [BLOCK_BITS-1:0]      ext_end,
	output seim_pkg::cell_flags_t      flags
);
	import seim_pkg::*;

	localparam int CMPW = (BLOCK_BITS + 1 > CNT_W) ? BLOCK_BITS + 1 : CNT_W;

	logic [BLOCK_BITS-1:0] start_q;
	logic [BLOCK_BITS-1:0] end_q;
	cell_flags_t           flags_q;
	logic [CMPW-1:0]       next_low;
	logic [CMPW-1:0]       after;
	logic [CMPW-1:0]       lo_x;
	logic [CMPW-1:0]       hi_x;

	// The gap after this extent runs up to the next extent, or to the table end.
	always_comb begin
		lo_x     = CMPW'(range_low);
		hi_x     = CMPW'(range_high);
		next_low = ctl.has_next ? CMPW'(next_start) : CMPW'(table_end);
		after    = CMPW'(end_q) + CMPW'(1);
	end

	always_ff @(posedge clk) begin
		flags_q.fit      <= ctl.occ && (hi_x < next_low) && (lo_x >= after);
		flags_q.left     <= (lo_x == after);
		flags_q.right    <= (hi_x + CMPW'(1) == next_low);
		flags_q.has_next <= ctl.has_next;
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			case (ctl.op)
				OP_APPEND: begin
					if (ctl.here) begin
						start_q <= range_low;
						end_q   <= range_high;
					end
				end
				OP_MERGE_NEXT: begin
					if (ctl.sel) begin
						end_q <= next_end;
					end else if (ctl.gt) begin
						start_q <= next_start;
						end_q   <= next_end;
					end
				end
				OP_SET_END: begin
					if (ctl.sel) begin
						end_q <= range_high;
					end
				end
				OP_SET_NEXT_LO: begin
					if (ctl.sel_prev) begin
						start_q <= range_low;
					end
				end
				OP_NEW: begin
					if (ctl.sel_prev) begin
						start_q <= range_low;
						end_q   <= range_high;
					end else if (ctl.gt) begin
						start_q <= prev_start;
						end_q   <= prev_end;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ext_start = start_q;
	assign ext_end   = end_q;
	assign flags     = flags_q;

endmodule

@@ hw/rtl/sorted_extent_insert_merge_top.sv @@
// One request at a time; input is not ready until its result is registered.
// The four steps are capture, compare in every cell, first-fit select, and
// the table update, which shifts later cells one place on an add or merge.
// A held result stalls the update step until the output register drains.
// Reset clears counts, configuration and handshake state; extent cells
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Sorted extent table top level
// Chain of extent cells with coalescing insert, append and clear requests.
// ----------------------------------------------------------------------------
`include "sorted_extent_insert_merge_top_defines.svh"

module sorted_extent_insert_merge_top #(
	parameter int MAX_EXTENTS = 64,
	parameter int BLOCK_BITS  = 36
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic                                      cfg_index,
	input  logic [seim_pkg::CNT_W-1:0]                cfg_data,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// range_low, range_high
	input  logic [((2*BLOCK_BITS+7)/8)*8-1:0]         s_tdata,
	// req_type
	input  logic [seim_pkg::REQ_W-1:0]                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// status, free_blocks, extent_count
	output logic [seim_pkg::OUT_DW-1:0]               m_tdata
);
	import seim_pkg::*;

	localparam int CW   = $clog2(MAX_EXTENTS + 1);
	localparam int LG   = $clog2(MAX_EXTENTS);
	localparam int CMPW = (BLOCK_BITS + 1 > CNT_W) ? BLOCK_BITS + 1 : CNT_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CMP   = 4'b0010,
		S_SEL   = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [REQ_W-1:0]        req_q;
	logic [BLOCK_BITS-1:0]   lo_q;
	logic [BLOCK_BITS-1:0]   hi_q;
	logic [CW-1:0]           count_q;
	logic [CNT_W-1:0]        free_q;
	logic [CNT_W-1:0]        table_end_q;
	logic [CNT_W-1:0]        init_free_q;

	logic                    inv_s1;
	logic [CMPW-1:0]         len_s1;

	logic [MAX_EXTENTS-1:0]  first_s2;
	logic [MAX_EXTENTS-1:0]  gt_s2;
	op_t                     op_s2;
	logic [STAT_W-1:0]       stat_s2;
	logic [CNT_W-1:0]        free_s2;
	logic [CW-1:0]           cnt_s2;

	logic                    m_tvalid_q;
	logic [OUT_DW-1:0]       m_tdata_q;

	logic                    out_free;
	logic                    apply_w;
	logic                    full;

	logic [BLOCK_BITS-1:0]   ext_start [MAX_EXTENTS];
	logic [BLOCK_BITS-1:0]   ext_end   [MAX_EXTENTS];
	cell_flags_t             flags     [MAX_EXTENTS];
	cell_ctl_t               ctl       [MAX_EXTENTS];
	logic [MAX_EXTENTS-1:0]  occ;
	logic [MAX_EXTENTS-1:0]  fit_v;
	logic [MAX_EXTENTS-1:0]  left_v;
	logic [MAX_EXTENTS-1:0]  right_v;
	logic [MAX_EXTENTS-1:0]  hasn_v;
	logic [MAX_EXTENTS-1:0]  pre [LG+1];
	logic [MAX_EXTENTS-1:0]  below;
	logic [MAX_EXTENTS-1:0]  first;
	logic                    any_fit;
	logic                    sel_left;
	logic                    sel_right;
	logic                    sel_hasn;
	logic [CMPW-1:0]         free_x;
	logic [CNT_W-1:0]        free_dec;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign apply_w  = (state_q == S_APPLY) && out_free;
	assign full     = (count_q == CW'(MAX_EXTENTS));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// Cell chain
	// ------------------------------------------------------------------
	genvar gi;
	generate
		for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
			logic [BLOCK_BITS-1:0] p_start;
			logic [BLOCK_BITS-1:0] p_end;
			logic [BLOCK_BITS-1:0] n_start;
			logic [BLOCK_BITS-1:0] n_end;
			logic                  occ_prev;
			logic                  sel_prev;
			logic                  occ_next;

			assign occ[gi] = (CW'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign p_start  = ext_start[gi];
				assign p_end    = ext_end[gi];
				assign occ_prev = 1'b1;
				assign sel_prev = 1'b0;
			end else begin : g_mid
				assign p_start  = ext_start[gi-1];
				assign p_end    = ext_end[gi-1];
				assign occ_prev = occ[gi-1];
				assign sel_prev = first_s2[gi-1];
			end

			if (gi == MAX_EXTENTS - 1) begin : g_last
				assign n_start  = ext_start[gi];
				assign n_end    = ext_end[gi];
				assign occ_next = 1'b0;
			end else begin : g_body
				assign n_start  = ext_start[gi+1];
				assign n_end    = ext_end[gi+1];
				assign occ_next = occ[gi+1];
			end

			always_comb begin
				ctl[gi].op       = op_s2;
				ctl[gi].apply    = apply_w;
				ctl[gi].sel      = first_s2[gi];
				ctl[gi].sel_prev = sel_prev;
				ctl[gi].gt       = gt_s2[gi];
				ctl[gi].occ      = occ[gi];
				ctl[gi].has_next = occ_next;
				ctl[gi].here     = occ_prev && !occ[gi];
			end

			seim_cell #(
				.BLOCK_BITS(BLOCK_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl[gi]),
				.range_low  (lo_q),
				.range_high (hi_q),
				.table_end  (table_end_q),
				.prev_start (p_start),
				.prev_end   (p_end),
				.next_start (n_start),
				.next_end   (n_end),
				.ext_start  (ext_start[gi]),
				.ext_end    (ext_end[gi]),
				.flags      (flags[gi])
			);

			assign fit_v[gi]   = flags[gi].fit;
			assign left_v[gi]  = flags[gi].left;
			assign right_v[gi] = flags[gi].right;
			assign hasn_v[gi]  = flags[gi].has_next;
		end
	endgenerate

	// ------------------------------------------------------------------
	// First fit: parallel prefix OR over the cell flags
	// ------------------------------------------------------------------
	always_comb begin
		pre[0] = fit_v;
		for (int k = 0; k < LG; k++) begin
			for (int i = 0; i < MAX_EXTENTS; i++) begin
				if (i >= (1 << k)) begin
					pre[k+1][i] = pre[k][i] | pre[k][i-(1<<k)];
				end else begin
					pre[k+1][i] = pre[k][i];
				end
			end
		end
		below     = {pre[LG][MAX_EXTENTS-2:0], 1'b0};
		any_fit   = pre[LG][MAX_EXTENTS-1];
		first     = fit_v & ~below;
		sel_left  = |(first & left_v);
		sel_right = |(first & right_v);
		sel_hasn  = |(first & hasn_v);
	end

	// Free count after a successful insert, saturating at zero.
	always_comb begin
		free_x   = CMPW'(free_q);
		free_dec = (free_x > len_s1) ? CNT_W'(free_x - len_s1) : '0;
	end

	// ------------------------------------------------------------------
	// Sequencer and stage registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP:   state_q <= S_SEL;
				S_SEL:   state_q <= S_APPLY;
				S_APPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= s_tuser;
			lo_q  <= s_tdata[BLOCK_BITS-1:0];
			hi_q  <= s_tdata[2*BLOCK_BITS-1:BLOCK_BITS];
		end
		inv_s1 <= (lo_q > hi_q);
		len_s1 <= CMPW'(hi_q) - CMPW'(lo_q) + CMPW'(1);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL) begin
			first_s2 <= first;
			gt_s2    <= below;
			op_s2    <= OP_NONE;
			stat_s2  <= STAT_DONE;
			free_s2  <= free_q;
			cnt_s2   <= count_q;
			case (req_q)
				REQ_CLEAR: begin
					op_s2   <= OP_CLEAR;
					free_s2 <= init_free_q;
					cnt_s2  <= '0;
				end
				REQ_APPEND: begin
					if (full) begin
						stat_s2 <= STAT_FULL;
					end else begin
						op_s2  <= OP_APPEND;
						cnt_s2 <= count_q + CW'(1);
					end
				end
				REQ_INSERT: begin
					if (inv_s1 || !any_fit) begin
						stat_s2 <= STAT_NOFIT;
					end else if (sel_left && sel_right && sel_hasn) begin
						op_s2   <= OP_MERGE_NEXT;
						cnt_s2  <= count_q - CW'(1);
						free_s2 <= free_dec;
					end else if (sel_left) begin
						op_s2   <= OP_SET_END;
						free_s2 <= free_dec;
					end else if (sel_right && sel_hasn) begin
						op_s2   <= OP_SET_NEXT_LO;
						free_s2 <= free_dec;
					end else if (full) begin
						stat_s2 <= STAT_FULL;
					end else begin
						op_s2   <= OP_NEW;
						cnt_s2  <= count_q + CW'(1);
						free_s2 <= free_dec;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Counts, configuration and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			free_q      <= '0;
			table_end_q <= '0;
			init_free_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_TABLE_END) begin
				table_end_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_INIT_FREE) begin
				init_free_q <= cfg_data;
			end
			if (apply_w) begin
				count_q    <= cnt_s2;
				free_q     <= free_s2;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_w) begin
			m_tdata_q <= OUT_DW'({XCNT_W'(cnt_s2), free_s2, stat_s2});
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SEIM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_EXTENTS),
		"extent count above table depth")
	`SEIM_ASSERT_NOW(a_single_pick, state_q == S_APPLY, $onehot0(first_s2),
		"more than one cell picked for the update")
	`SEIM_ASSERT_NEXT(a_accept_cmp, s_tvalid && s_tready, state_q == S_CMP,
		"input transfer did not start the compare step")
	`SEIM_ASSERT_NEXT(a_new_grows, apply_w && op_s2 == OP_NEW,
		count_q == CW'($past(count_q) + CW'(1)),
		"new extent did not grow the table by one")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted extent table testbench
// Drives clear, append and insert requests through the input stream, predicts
// every result from a local copy of the extent table, and checks each output
// transfer field by field. The run goes through several register settings,
// random idling on both stream sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import seim_pkg::*;

	localparam int          MAX_EXT     = 64;
	localparam int          BLK_W       = 36;
	localparam logic [63:0] BLK_LIMIT   = 64'h10_0000_0000;
	localparam logic [63:0] BLK_MASK    = BLK_LIMIT - 64'd1;
	localparam int          STALL_LIMIT = 3000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          SPAN        = 600;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		logic [BLK_W-1:0] lo;
		logic [BLK_W-1:0] hi;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  free_blocks;
		logic [XCNT_W-1:0] extent_count;
	} outcome_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = CFG_TABLE_END;
	logic [CNT_W-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [2*BLK_W-1:0]  s_tdata   = '0;
	logic [REQ_W-1:0]    s_tuser   = REQ_CLEAR;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;

	// Local copy of the extent table and its registers.
	logic [63:0] ext_first [MAX_EXT];
	logic [63:0] ext_last [MAX_EXT];
	int          ext_used;
	logic [63:0] free_left;
	logic [63:0] reg_table_end;
	logic [63:0] reg_init_free;

	request_t pending_requests [$];
	outcome_t expected_results [$];
	request_t next_req;

	int items_pushed;
	int results_seen;
	int mismatch_count;
	int src_wait;
	int sink_wait;
	int hold_left;
	int quiet_cycles;
	bit src_idle_en;
	bit sink_idle_en;
	bit pressure_arm;
	bit pressure_done;

	sorted_extent_insert_merge_top #(
		.MAX_EXTENTS(MAX_EXT),
		.BLOCK_BITS (BLK_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// First-fit insert with coalescing into the gap after the chosen extent.
	function automatic logic [STAT_W-1:0] insert_range(input logic [63:0] lo,
			input logic [63:0] hi);
		logic [63:0] gap_end;
		logic [63:0] after;
		logic [63:0] len;
		logic        has_nxt;
		logic        lft;
		logic        rgt;
		int          j;
		if (lo > hi)
			return STAT_NOFIT;
		for (int i = 0; i < ext_used; i++) begin
			has_nxt = (i + 1) < ext_used;
			gap_end = has_nxt ? ext_first[i + 1] : reg_table_end;
			after = ext_last[i] + 64'd1;
			if (hi >= gap_end || lo < after)
				continue;
			lft = (lo == after);
			rgt = (hi == gap_end - 64'd1);
			if (lft && rgt && has_nxt) begin
				ext_last[i] = ext_last[i + 1];
				for (j = i + 1; j < ext_used - 1; j++) begin
					ext_first[j] = ext_first[j + 1];
					ext_last[j] = ext_last[j + 1];
				end
				ext_used--;
			end else if (lft) begin
				ext_last[i] = hi;
			end else if (rgt && has_nxt) begin
				ext_first[i + 1] = lo;
			end else begin
				if (ext_used >= MAX_EXT)
					return STAT_FULL;
				for (j = ext_used; j > i + 1; j--) begin
					ext_first[j] = ext_first[j - 1];
					ext_last[j] = ext_last[j - 1];
				end
				ext_first[i + 1] = lo;
				ext_last[i + 1] = hi;
				ext_used++;
			end
			len = hi - lo + 64'd1;
			free_left = (free_left > len) ? free_left - len : 64'd0;
			return STAT_DONE;
		end
		return STAT_NOFIT;
	endfunction

	function automatic outcome_t extent_table_step(input logic [REQ_W-1:0] kind,
			input logic [BLK_W-1:0] lo, input logic [BLK_W-1:0] hi);
		outcome_t res;
		res.status = STAT_DONE;
		case (kind)
			REQ_CLEAR: begin
				ext_used = 0;
				free_left = reg_init_free;
			end
			REQ_APPEND: begin
				if (ext_used >= MAX_EXT) begin
					res.status = STAT_FULL;
				end else begin
					ext_first[ext_used] = 64'(lo);
					ext_last[ext_used] = 64'(hi);
					ext_used++;
				end
			end
			REQ_INSERT: begin
				res.status = insert_range(64'(lo), 64'(hi));
			end
			default: ;
		endcase
		res.free_blocks = free_left[CNT_W-1:0];
		res.extent_count = ext_used[XCNT_W-1:0];
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_idle(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic logic [63:0] any_block();
		return {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (mismatch_count < 100)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	task automatic check_result(input logic [OUT_DW-1:0] word);
		outcome_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result", 64'd0, 64'(word));
			return;
		end
		want = expected_results.pop_front();
		if (word[1:0] !== want.status)
			report_mismatch("status", 64'(want.status), 64'(word[1:0]));
		if (word[38:2] !== want.free_blocks)
			report_mismatch("free_blocks", 64'(want.free_blocks), 64'(word[38:2]));
		if (word[45:39] !== want.extent_count)
			report_mismatch("extent_count", 64'(want.extent_count), 64'(word[45:39]));
	endtask

	task automatic push_request(input logic [REQ_W-1:0] kind, input logic [63:0] lo,
			input logic [63:0] hi);
		request_t r;
		r.kind = kind;
		r.lo = lo[BLK_W-1:0];
		r.hi = hi[BLK_W-1:0];
		pending_requests.push_back(r);
		items_pushed++;
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CNT_W-1:0];
		if (idx == CFG_TABLE_END)
			reg_table_end = val;
		else
			reg_init_free = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Every request yields one result, so the table is idle once all have come.
	task automatic drain();
		wait (results_seen >= items_pushed);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= REQ_CLEAR;
			src_wait <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(extent_table_step(s_tuser, s_tdata[BLK_W-1:0],
					s_tdata[2*BLK_W-1:BLK_W]));
			if (!s_tvalid || s_tready) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_req.kind;
					s_tdata <= {next_req.hi, next_req.lo};
					src_wait <= pick_idle(src_idle_en);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
			pressure_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (pressure_arm && !pressure_done) begin
				// Long hold-off so the table backs up and stalls its input.
				pressure_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tready && sink_idle_en && $urandom_range(0, 4) == 0)
					sink_wait <= pick_idle(1'b1);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("sorted_extent_insert_merge_top verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [63:0] base;
		logic [63:0] end_blk;
		logic [63:0] free0;
		logic [63:0] cursor;
		logic [63:0] lo;
		logic [63:0] hi;
		int          n_app;
		int          r;
		ext_used = 0;
		free_left = '0;
		reg_table_end = '0;
		reg_init_free = '0;
		items_pushed = 0;
		results_seen = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		pressure_arm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_TABLE_END, 64'd100);
		write_reg(CFG_INIT_FREE, 64'd50);
		push_request(REQ_INSERT, 64'd5, 64'd9);      // empty table
		push_request(REQ_CLEAR, 64'd0, 64'd0);
		push_request(REQ_INSERT, 64'd5, 64'd9);
		push_request(REQ_APPEND, 64'd10, 64'd20);
		push_request(REQ_APPEND, 64'd40, 64'd50);
		push_request(REQ_INSERT, 64'd30, 64'd35);    // new extent between two
		push_request(REQ_INSERT, 64'd21, 64'd25);    // extends the left extent
		push_request(REQ_INSERT, 64'd36, 64'd39);    // closes a gap on both sides
		push_request(REQ_INSERT, 64'd26, 64'd28);
		push_request(REQ_INSERT, 64'd29, 64'd29);
		push_request(REQ_INSERT, 64'd15, 64'd18);    // overlaps, so no fit
		push_request(REQ_INSERT, 64'd60, 64'd99);    // reaches the table end, saturates the free count
		push_request(REQ_INSERT, 64'd53, 64'd53);
		push_request(REQ_INSERT, 64'd56, 64'd59);    // extends the right extent
		push_request(REQ_INSERT, 64'd54, 64'd55);    // closes a gap on both sides
		push_request(REQ_INSERT, 64'd20, 64'd10);    // inverted range
		push_request(REQ_INSERT, BLK_MASK, BLK_MASK);
		push_request(REQ_INSERT, 64'd0, BLK_MASK);
		push_request(REQ_APPEND, BLK_MASK, BLK_MASK);
		push_request(REQ_APPEND, 64'd0, 64'd0);      // out of order on purpose
		push_request(REQ_CLEAR, 64'd0, 64'd0);

		for (int p = 0; p < 12; p++) begin
			drain();
			src_idle_en = (p % 4) != 1;
			sink_idle_en = (p % 4) != 1;
			if (p == 5)
				pressure_arm = 1'b1;
			case (p)
				2: begin
					base = 64'd0;
					end_blk = 64'd0;
					free0 = 64'd0;
				end
				3: begin
					base = BLK_LIMIT - SPAN;
					end_blk = BLK_LIMIT;
					free0 = BLK_LIMIT;
				end
				6: begin
					base = any_block() % (BLK_LIMIT - SPAN);
					end_blk = base + SPAN;
					free0 = 64'd7;
				end
				9: begin
					// Table end falls short of some extents.
					base = any_block() % (BLK_LIMIT - SPAN);
					end_blk = base + SPAN / 2;
					free0 = any_block();
				end
				default: begin
					base = (p % 3 == 0) ? 64'd0 : any_block() % (BLK_LIMIT - SPAN);
					end_blk = base + SPAN;
					free0 = (p % 2 == 1) ? any_block() : 64'($urandom_range(0, 3000));
				end
			endcase
			write_reg(CFG_TABLE_END, end_blk);
			write_reg(CFG_INIT_FREE, free0);

			push_request(REQ_CLEAR, 64'd0, 64'd0);
			n_app = (p == 7) ? MAX_EXT : (p == 8) ? MAX_EXT + 2 : $urandom_range(0, 40);
			cursor = base;
			for (int a = 0; a < n_app; a++) begin
				lo = cursor + $urandom_range(1, 5);
				hi = lo + $urandom_range(0, 3);
				push_request(REQ_APPEND, lo, hi);
				cursor = hi;
			end

			for (int k = 0; k < 85; k++) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					lo = base + $urandom_range(0, SPAN - 1);
					hi = lo + $urandom_range(0, 3);
					if (hi > BLK_MASK)
						hi = BLK_MASK;
					push_request(REQ_INSERT, lo, hi);
				end else if (r < 86) begin
					hi = base + $urandom_range(0, SPAN - 2);
					lo = hi + $urandom_range(1, 5);
					push_request(REQ_INSERT, lo, hi);
				end else if (r < 91) begin
					push_request(REQ_INSERT, any_block(), any_block());
				end else if (r < 95) begin
					lo = base + $urandom_range(0, SPAN - 8);
					push_request(REQ_APPEND, lo, lo + $urandom_range(0, 3));
				end else if (r < 97) begin
					push_request(REQ_CLEAR, any_block(), any_block());
				end else begin
					push_request(REQ_APPEND, any_block(), any_block());
				end
			end
		end

		drain();
		if (expected_results.size() != 0)
			report_mismatch("results missing", 64'(expected_results.size()), 64'd0);
		if (mismatch_count == 0)
			$display("sorted_extent_insert_merge_top verification clean");
		else
			$display("sorted_extent_insert_merge_top verification failed");
		$finish;
	end

endmodule
